// ----- src/stps_pkg.sv -----
// Shared types and codes for the search task priority scheduler.
// No dependencies; imported by stps_ctrl, stps_dp, the top level and stps_chk.
`timescale 1ns / 1ps
package stps_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_RECORD = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CFG_LINES   = 2'd0;
  localparam logic [1:0] CFG_PRIO    = 2'd1;
  localparam logic [1:0] CFG_WORKERS = 2'd2;

  localparam int TASK_W = 28;
  localparam int CELL_W = 23;

  localparam logic signed [22:0] SCORE_FLOOR = {1'b1, 22'd0};

  typedef struct packed {
    logic [15:0] tag;
    logic [5:0]  line;
    logic [5:0]  depth;
  } task_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic decode;
    logic push_wr;
    logic rec_wr;
    logic div_load;
    logic div_step;
    logic div_fin;
    logic task_got;
    logic cell_eval;
    logic rank_rd;
    logic rank_got;
    logic rank_judge;
    logic next_task;
    logic sel;
    logic out_got;
    logic shift_rd;
    logic shift_wr;
    logic pop_fin;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       div_skip;
    logic       div_last;
    logic       low_hit;
    logic       cand;
    logic       rank_last;
    logic       scan_last;
    logic       shift_done;
    logic       out_free;
  } sts_t;

endpackage

// ----- src/stps_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module stps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/stps_ctrl.sv -----
// Sequencing state machine of the scheduler: issues commands to the datapath.
// Depends on stps_pkg.
`timescale 1ns / 1ps
module stps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  stps_pkg::sts_t sts,
  output stps_pkg::cmd_t cmd
);
  import stps_pkg::*;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DEC    = 5'd2;
  localparam logic [4:0] S_PUSHW  = 5'd3;
  localparam logic [4:0] S_REC    = 5'd4;
  localparam logic [4:0] S_DIVLD  = 5'd5;
  localparam logic [4:0] S_DIV    = 5'd6;
  localparam logic [4:0] S_DIVFIN = 5'd7;
  localparam logic [4:0] S_TRD    = 5'd8;
  localparam logic [4:0] S_TGOT   = 5'd9;
  localparam logic [4:0] S_CEVAL  = 5'd10;
  localparam logic [4:0] S_RRD    = 5'd11;
  localparam logic [4:0] S_RGOT   = 5'd12;
  localparam logic [4:0] S_RJ     = 5'd13;
  localparam logic [4:0] S_NEXT   = 5'd14;
  localparam logic [4:0] S_SEL    = 5'd15;
  localparam logic [4:0] S_OGOT   = 5'd16;
  localparam logic [4:0] S_SHR    = 5'd17;
  localparam logic [4:0] S_SHW    = 5'd18;
  localparam logic [4:0] S_FIN    = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        case (sts.op)
          OP_PUSH:   state_next = sts.full ? S_DONE : S_PUSHW;
          OP_POP:    state_next = sts.empty ? S_DONE : S_TRD;
          OP_RECORD: state_next = S_REC;
          default:   state_next = S_DONE;
        endcase
      end
      S_PUSHW: begin
        cmd.push_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_REC: begin
        cmd.rec_wr = 1'b1;
        state_next = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_next   = sts.div_skip ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DIVFIN;
      end
      S_DIVFIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_DONE;
      end
      S_TRD: begin
        state_next = S_TGOT;
      end
      S_TGOT: begin
        cmd.task_got = 1'b1;
        state_next   = sts.low_hit ? S_SEL : S_CEVAL;
      end
      S_CEVAL: begin
        cmd.cell_eval = 1'b1;
        state_next    = sts.cand ? S_RRD : S_NEXT;
      end
      S_RRD: begin
        cmd.rank_rd = 1'b1;
        state_next  = S_RGOT;
      end
      S_RGOT: begin
        cmd.rank_got = 1'b1;
        state_next   = sts.rank_last ? S_RJ : S_RRD;
      end
      S_RJ: begin
        cmd.rank_judge = 1'b1;
        state_next     = S_NEXT;
      end
      S_NEXT: begin
        cmd.next_task = 1'b1;
        state_next    = sts.scan_last ? S_SEL : S_TRD;
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_OGOT;
      end
      S_OGOT: begin
        cmd.out_got = 1'b1;
        state_next  = S_SHR;
      end
      S_SHR: begin
        if (sts.shift_done) begin
          state_next = S_FIN;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHW;
        end
      end
      S_SHW: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHR;
      end
      S_FIN: begin
        cmd.pop_fin = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/stps_dp.sv -----
// Datapath of the scheduler: task list, result table, counters, divider, output register.
// Depends on stps_pkg and stps_ram.
`timescale 1ns / 1ps
module stps_dp #(
  parameter int TASK_SLOTS   = 64,
  parameter int MAX_LINES    = 64,
  parameter int DEPTH_LEVELS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stps_pkg::cmd_t       cmd,
  output stps_pkg::sts_t       sts,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data,
  input  logic [1:0]           op,
  input  logic [5:0]           line_index,
  input  logic [5:0]           depth_level,
  input  logic [15:0]          task_tag,
  input  logic signed [21:0]   score_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [15:0]          out_tag,
  output logic [5:0]           out_line,
  output logic [5:0]           out_depth,
  output logic [6:0]           push_allowance
);
  import stps_pkg::*;

  localparam int AW    = $clog2(TASK_SLOTS);
  localparam int CW    = $clog2(TASK_SLOTS + 1);
  localparam int CELLS = MAX_LINES * DEPTH_LEVELS;
  localparam int RAW   = $clog2(CELLS);

  function automatic logic [RAW-1:0] cell_addr(input logic [6:0] ln, input logic [5:0] d);
    cell_addr = RAW'(int'(ln) * DEPTH_LEVELS + int'(d));
  endfunction

  // configuration
  logic [6:0] line_count, top_lines, worker_count, n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= 7'd1;
      top_lines    <= 7'd3;
      worker_count <= 7'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LINES:   line_count   <= cfg_data;
        CFG_PRIO:    top_lines    <= cfg_data;
        CFG_WORKERS: worker_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff = (line_count == 7'd0) ? 7'd1 :
                 (int'(line_count) > MAX_LINES) ? 7'(MAX_LINES) : line_count;

  // captured transaction
  logic [1:0]         c_op;
  logic [5:0]         c_line, c_depth;
  logic [15:0]        c_tag;
  logic signed [21:0] c_score;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_op    <= op;
      c_line  <= line_index;
      c_depth <= depth_level;
      c_tag   <= task_tag;
      c_score <= score_in;
    end
  end

  // memories
  logic            t_we;
  logic [AW-1:0]   t_addr;
  task_t           t_wdata, t_rdata;
  logic            r_we;
  logic [RAW-1:0]  r_addr;
  logic [CELL_W-1:0] r_wdata, r_rdata;

  stps_ram #(.WIDTH(TASK_W), .DEPTH(TASK_SLOTS)) u_task_ram (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
  );

  stps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata)
  );

  // control state
  logic [CW-1:0]  count;
  logic [6:0]     busy;
  logic [RAW-1:0] clr_addr;

  // scan state
  logic [AW-1:0]         scan_i, k, sel_idx;
  logic [5:0]            cur_depth, cur_pd;
  logic signed [22:0]    cur_s;
  logic                  cell_ok;
  logic                  low_found, nfound, pfound;
  logic [AW-1:0]         low_idx, nb_idx, pb_idx;
  logic [5:0]            nb_depth, pb_depth;
  logic signed [22:0]    nb_score, pb_score;
  logic [6:0]            j, better, total;

  // divider
  logic [7:0] rem, rem_sh;
  logic [6:0] dvd, avail;
  logic [2:0] div_cnt;
  logic       q_bit;

  // result being built
  logic [1:0]  res_status;
  logic [15:0] res_tag;
  logic [5:0]  res_line, res_depth;
  logic [6:0]  res_allow;

  logic               rec_ok, pd_ok, reached, rr, in_top;
  logic [5:0]         pd_now;
  logic signed [22:0] s_now, cell_s;

  assign rec_ok = (int'(c_line) < MAX_LINES) && (int'(c_depth) < DEPTH_LEVELS);
  assign pd_now = t_rdata.depth - 6'd1;
  assign pd_ok  = (int'(t_rdata.line) < MAX_LINES) && (int'(pd_now) < DEPTH_LEVELS);
  assign cell_s = $signed({r_rdata[21], r_rdata[21:0]});
  assign reached = cell_ok & r_rdata[22];
  assign rr      = reached;
  assign s_now   = reached ? cell_s : SCORE_FLOOR;
  assign sel_idx = low_found ? low_idx : (pfound ? pb_idx : nb_idx);
  assign in_top  = (top_lines == 7'd0) ? (better == 7'd0)
                 : ((better < top_lines) && (total >= top_lines));
  assign avail   = (worker_count > busy) ? (worker_count - busy) : 7'd0;
  assign rem_sh  = {rem[6:0], dvd[6]};
  assign q_bit   = (rem_sh >= {1'b0, n_eff});

  always_comb begin
    t_we    = 1'b0;
    t_addr  = scan_i;
    t_wdata = t_rdata;
    if (cmd.push_wr) begin
      t_we    = 1'b1;
      t_addr  = AW'(count);
      t_wdata = '{tag: c_tag, line: c_line, depth: c_depth};
    end else if (cmd.sel) begin
      t_addr = sel_idx;
    end else if (cmd.shift_rd) begin
      t_addr = AW'(CW'(k) + CW'(1));
    end else if (cmd.shift_wr) begin
      t_we   = 1'b1;
      t_addr = k;
    end
  end

  always_comb begin
    r_we    = 1'b0;
    r_addr  = cell_addr({1'b0, t_rdata.line}, pd_now);
    r_wdata = '0;
    if (cmd.clr_step) begin
      r_we   = 1'b1;
      r_addr = clr_addr;
    end else if (cmd.rec_wr) begin
      r_we    = rec_ok;
      r_addr  = cell_addr({1'b0, c_line}, c_depth);
      r_wdata = {1'b1, c_score};
    end else if (cmd.rank_rd) begin
      r_addr = cell_addr(j, cur_pd);
    end
  end

  always_comb begin
    sts.clr_last   = (clr_addr == RAW'(CELLS - 1));
    sts.op         = c_op;
    sts.full       = (count == CW'(TASK_SLOTS));
    sts.empty      = (count == '0);
    sts.div_skip   = (n_eff > worker_count);
    sts.div_last   = (div_cnt == 3'd6);
    sts.low_hit    = (t_rdata.depth <= 6'd1);
    sts.cand       = reached && (!pfound || (cur_depth < pb_depth) ||
                     ((cur_depth == pb_depth) && (s_now > pb_score)));
    sts.rank_last  = (j == n_eff - 7'd1);
    sts.scan_last  = ((CW'(scan_i) + CW'(1)) == count);
    sts.shift_done = ((CW'(k) + CW'(1)) >= count);
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      busy     <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + RAW'(1);
      if (cmd.push_wr) count <= count + CW'(1);
      if (cmd.pop_fin) begin
        count <= count - CW'(1);
        if (busy != 7'h7F) busy <= busy + 7'd1;
      end
      if (cmd.rec_wr && busy != 7'd0) busy <= busy - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status <= ST_OK;
      res_tag    <= '0;
      res_line   <= '0;
      res_depth  <= '0;
      res_allow  <= '0;
    end
    if (cmd.decode) begin
      if (c_op == OP_PUSH && sts.full) res_status <= ST_FULL;
      if (c_op == OP_POP && sts.empty) res_status <= ST_EMPTY;
      scan_i    <= '0;
      low_found <= 1'b0;
      nfound    <= 1'b0;
      pfound    <= 1'b0;
    end
    if (cmd.task_got) begin
      cur_depth <= t_rdata.depth;
      cur_pd    <= pd_now;
      cell_ok   <= pd_ok;
      if (t_rdata.depth <= 6'd1) begin
        low_found <= 1'b1;
        low_idx   <= scan_i;
      end
    end
    if (cmd.cell_eval) begin
      cur_s  <= s_now;
      j      <= '0;
      better <= '0;
      total  <= '0;
      if (!nfound || (cur_depth < nb_depth) ||
          ((cur_depth == nb_depth) && (s_now > nb_score))) begin
        nfound   <= 1'b1;
        nb_depth <= cur_depth;
        nb_score <= s_now;
        nb_idx   <= scan_i;
      end
    end
    if (cmd.rank_rd) cell_ok <= (int'(cur_pd) < DEPTH_LEVELS);
    if (cmd.rank_got) begin
      if (rr) total <= total + 7'd1;
      if (rr && cell_s > cur_s) better <= better + 7'd1;
      j <= j + 7'd1;
    end
    if (cmd.rank_judge && in_top) begin
      pfound   <= 1'b1;
      pb_depth <= cur_depth;
      pb_score <= cur_s;
      pb_idx   <= scan_i;
    end
    if (cmd.next_task) scan_i <= scan_i + AW'(1);
    if (cmd.sel) k <= sel_idx;
    if (cmd.out_got) begin
      res_tag   <= t_rdata.tag;
      res_line  <= t_rdata.line;
      res_depth <= t_rdata.depth;
    end
    if (cmd.shift_wr) k <= k + AW'(1);
    if (cmd.div_load) begin
      rem     <= '0;
      dvd     <= avail;
      div_cnt <= '0;
      if (sts.div_skip) res_allow <= 7'd1;
    end
    if (cmd.div_step) begin
      rem     <= q_bit ? (rem_sh - {1'b0, n_eff}) : rem_sh;
      dvd     <= {dvd[5:0], q_bit};
      div_cnt <= div_cnt + 3'd1;
    end
    if (cmd.div_fin) res_allow <= (dvd == 7'h7F) ? 7'h7F : dvd + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status         <= res_status;
      out_tag        <= res_tag;
      out_line       <= res_line;
      out_depth      <= res_depth;
      push_allowance <= res_allow;
    end
  end

endmodule

// ----- src/search_task_priority_scheduler_unit.sv -----
// Top level of the search task priority scheduler: controller plus datapath.
// Depends on stps_pkg, stps_ctrl, stps_dp, stps_ram.
//
//  channel   handshake              payload
//  in        in_valid / in_ready    op, line_index, depth_level, task_tag, score_in
//  out       out_valid / out_ready  status, out_tag, out_line, out_depth, push_allowance
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Push: capture, decode, task-list write. Record: capture, decode, result-table write, divider
// load, then the division (one quotient bit a cycle) unless skipped. Pop: each queued task is
// read and ranked if needed, later entries shift down; one result-table port sets the pace.
// After reset a clearing pass over all MAX_LINES*DEPTH_LEVELS cells runs before in_ready rises.
// A stalled output holds the next transaction in its final state until the register frees.
`timescale 1ns / 1ps
module search_task_priority_scheduler_unit #(
  parameter int TASK_SLOTS   = 64,
  parameter int MAX_LINES    = 64,
  parameter int DEPTH_LEVELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [5:0]          line_index,
  input  logic [5:0]          depth_level,
  input  logic [15:0]         task_tag,
  input  logic signed [21:0]  score_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [15:0]         out_tag,
  output logic [5:0]          out_line,
  output logic [5:0]          out_depth,
  output logic [6:0]          push_allowance,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import stps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  stps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  stps_dp #(
    .TASK_SLOTS(TASK_SLOTS), .MAX_LINES(MAX_LINES), .DEPTH_LEVELS(DEPTH_LEVELS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .line_index(line_index), .depth_level(depth_level),
    .task_tag(task_tag), .score_in(score_in),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .out_tag(out_tag), .out_line(out_line), .out_depth(out_depth),
    .push_allowance(push_allowance)
  );

endmodule

// ----- src/stps_chk.sv -----
// Port-level checks for the scheduler, bound to the top level.
// Depends on stps_pkg and search_task_priority_scheduler_unit.
`timescale 1ns / 1ps
module stps_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] out_tag,
  input logic [5:0]  out_line,
  input logic [5:0]  out_depth,
  input logic [6:0]  push_allowance
);
  import stps_pkg::*;

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a busy cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |->
      (out_tag == 16'd0 && out_line == 6'd0 && out_depth == 6'd0 && push_allowance == 7'd0))
    else $error("empty pop carries data");

  a_allow_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && push_allowance != 7'd0) |-> (status == ST_OK && out_tag == 16'd0))
    else $error("allowance on a non-record transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(out_tag)))
    else $error("stalled result changed");

endmodule

bind search_task_priority_scheduler_unit stps_chk u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .out_tag(out_tag), .out_line(out_line), .out_depth(out_depth),
  .push_allowance(push_allowance)
);
